// ===== hw/rtl/owts_pkg.sv =====
// Shared types and constants for the one-wire temperature sensor master.
package owts_pkg;

    localparam int READ_BITS = 16;
    localparam int DATA_W    = 16;
    localparam int TICK_W    = 16;
    localparam int BIT_W     = $clog2(READ_BITS + 1);
    localparam int CFG_IDX_W = 8;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [TICK_W-1:0] GAP_AFTER_SKIP  = TICK_W'(30);
    localparam logic [TICK_W-1:0] GAP_BEFORE_READ = TICK_W'(2);
    localparam logic [TICK_W-1:0] WRITE_RECOVERY  = TICK_W'(4);

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_CONV  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_POLL  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 8'd0,
        CFG_PRESENCE_WAIT = 8'd1,
        CFG_RESET_REC     = 8'd2,
        CFG_WRITE_SLOT    = 8'd3,
        CFG_READ_LOW      = 8'd4,
        CFG_READ_SAMPLE   = 8'd5,
        CFG_READ_REC      = 8'd6,
        CFG_POLL_WAIT     = 8'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] reset_recovery_ticks;
        logic [TICK_W-1:0] write_slot_ticks;
        logic [TICK_W-1:0] read_low_ticks;
        logic [TICK_W-1:0] read_sample_ticks;
        logic [TICK_W-1:0] read_recovery_ticks;
        logic [TICK_W-1:0] poll_wait_ticks;
    } timing_t;

endpackage

// ===== hw/rtl/owts_if.sv =====
// Channel interfaces: tick input, result output and configuration write.
interface owts_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [1:0] req_type;
    logic       line_in;

    modport source (output valid, cmd_valid, req_type, line_in, input ready);
    modport sink   (input valid, cmd_valid, req_type, line_in, output ready);
endinterface

interface owts_out_if;
    logic        valid;
    logic        ready;
    logic        line_drive_low;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] read_data;
    logic        conversion_done;
    logic        sensor_present;

    modport source (output valid, line_drive_low, busy_res, done_res, status, read_data,
                    conversion_done, sensor_present, input ready);
    modport sink   (input valid, line_drive_low, busy_res, done_res, status, read_data,
                    conversion_done, sensor_present, output ready);
endinterface

interface owts_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/owts_cfg_regs.sv =====
// Timing register file written through the configuration channel.
module owts_cfg_regs
    import owts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    owts_cfg_if.sink          cfg,
    output timing_t           timing
);

    timing_t timing_reg;

    assign cfg.ready = 1'b1;
    assign timing    = timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_ticks      <= TICK_W'(1700);
            timing_reg.presence_wait_ticks  <= TICK_W'(300);
            timing_reg.reset_recovery_ticks <= TICK_W'(1030);
            timing_reg.write_slot_ticks     <= TICK_W'(300);
            timing_reg.read_low_ticks       <= TICK_W'(10);
            timing_reg.read_sample_ticks    <= TICK_W'(10);
            timing_reg.read_recovery_ticks  <= TICK_W'(150);
            timing_reg.poll_wait_ticks      <= TICK_W'(100);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RESET_LOW:     timing_reg.reset_low_ticks      <= cfg.data;
                CFG_PRESENCE_WAIT: timing_reg.presence_wait_ticks  <= cfg.data;
                CFG_RESET_REC:     timing_reg.reset_recovery_ticks <= cfg.data;
                CFG_WRITE_SLOT:    timing_reg.write_slot_ticks     <= cfg.data;
                CFG_READ_LOW:      timing_reg.read_low_ticks       <= cfg.data;
                CFG_READ_SAMPLE:   timing_reg.read_sample_ticks    <= cfg.data;
                CFG_READ_REC:      timing_reg.read_recovery_ticks  <= cfg.data;
                CFG_POLL_WAIT:     timing_reg.poll_wait_ticks      <= cfg.data;
                default:           ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/owts_seq.sv =====
// Bus sequencer: one tick per accepted word, result word registered.
module owts_seq
    import owts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  timing_t   timing,
    owts_in_if.sink   in_ch,
    owts_out_if.source out_ch
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_WR_LOW, PH_WR_DATA, PH_WR_REC, PH_GAP1, PH_GAP2,
        PH_RD_LOW, PH_RD_WAIT, PH_RD_REC, PH_POLL
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [DATA_W-1:0]   shift_reg, shift_next;
    logic                bsel_reg, bsel_next;
    logic                status_reg, status_next;
    logic                present_reg, present_next;
    logic                conv_reg, conv_next;

    logic                out_valid_reg;
    logic                drive_reg, drive_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic                accept;
    logic [TICK_W-1:0]   dur;
    logic [TICK_W:0]     tick_inc;
    logic [7:0]          cur_byte;
    logic [BIT_W-1:0]    bit_inc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        cmd_next     = cmd_reg;
        shift_next   = shift_reg;
        bsel_next    = bsel_reg;
        status_next  = status_reg;
        present_next = present_reg;
        conv_next    = conv_reg;
        drive_next   = 1'b0;
        busy_next    = 1'b0;
        done_next    = 1'b0;
        dur          = TICK_W'(1);
        cur_byte     = CMD_SKIP_ROM;
        tick_inc     = '0;
        bit_inc      = '0;

        if (phase_reg == PH_IDLE && in_ch.cmd_valid)
        begin
            cmd_next    = in_ch.req_type;
            status_next = 1'b0;
            bit_next    = '0;
            bsel_next   = 1'b0;
            tick_next   = '0;
            phase_next  = (in_ch.req_type == REQ_POLL) ? PH_POLL : PH_RST_LOW;
        end

        if (bsel_next)
            cur_byte = (cmd_next == REQ_CONV) ? CMD_CONVERT : CMD_READ_PAD;

        unique case (phase_next)
            PH_RST_LOW:  dur = timing.reset_low_ticks;
            PH_RST_WAIT: dur = timing.presence_wait_ticks;
            PH_RST_REC:  dur = timing.reset_recovery_ticks;
            PH_WR_DATA:  dur = timing.write_slot_ticks;
            PH_WR_REC:   dur = WRITE_RECOVERY;
            PH_GAP1:     dur = GAP_AFTER_SKIP;
            PH_GAP2:     dur = GAP_BEFORE_READ;
            PH_RD_LOW:   dur = timing.read_low_ticks;
            PH_RD_WAIT:  dur = timing.read_sample_ticks;
            PH_RD_REC:   dur = timing.read_recovery_ticks;
            PH_POLL:     dur = timing.poll_wait_ticks;
            default:     dur = TICK_W'(1);
        endcase

        if (phase_next != PH_IDLE)
        begin
            busy_next  = 1'b1;
            drive_next = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                         (phase_next == PH_RD_LOW) ||
                         ((phase_next == PH_WR_DATA) && !cur_byte[bit_next[2:0]]);
            tick_inc   = {1'b0, tick_next} + 1'b1;
            tick_next  = tick_inc[TICK_W-1:0];
            bit_inc    = bit_next + 1'b1;

            if (tick_inc >= {1'b0, dur})
            begin
                tick_next = '0;
                unique case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        if (in_ch.line_in)
                        begin
                            present_next = 1'b0;
                            status_next  = 1'b1;
                            phase_next   = PH_IDLE;
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            present_next = 1'b1;
                            phase_next   = PH_RST_REC;
                        end
                    end
                    PH_RST_REC:
                    begin
                        bsel_next  = 1'b0;
                        bit_next   = '0;
                        phase_next = PH_WR_LOW;
                    end
                    PH_WR_LOW:   phase_next = PH_WR_DATA;
                    PH_WR_DATA:  phase_next = PH_WR_REC;
                    PH_WR_REC:
                    begin
                        bit_next = bit_inc;
                        if (bit_inc < BIT_W'(8))
                            phase_next = PH_WR_LOW;
                        else if (!bsel_next)
                        begin
                            if (cmd_next == REQ_INIT)
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                                phase_next = PH_GAP1;
                        end
                        else if (cmd_next == REQ_CONV)
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                            phase_next = PH_GAP2;
                    end
                    PH_GAP1:
                    begin
                        bsel_next  = 1'b1;
                        bit_next   = '0;
                        phase_next = PH_WR_LOW;
                    end
                    PH_GAP2:
                    begin
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                    end
                    PH_RD_LOW:   phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        // shift past the top bit yields zero, so extra bits drop out
                        if (in_ch.line_in)
                            shift_next = shift_next | (DATA_W'(1) << bit_next);
                        phase_next = PH_RD_REC;
                    end
                    PH_RD_REC:
                    begin
                        bit_next = bit_inc;
                        if (bit_inc >= BIT_W'(READ_BITS))
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                            phase_next = PH_RD_LOW;
                    end
                    PH_POLL:
                    begin
                        conv_next  = in_ch.line_in;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            cmd_reg       <= '0;
            shift_reg     <= '0;
            bsel_reg      <= 1'b0;
            status_reg    <= 1'b0;
            present_reg   <= 1'b0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                cmd_reg       <= cmd_next;
                shift_reg     <= shift_next;
                bsel_reg      <= bsel_next;
                status_reg    <= status_next;
                present_reg   <= present_next;
                conv_reg      <= conv_next;
                drive_reg     <= drive_next;
                busy_reg      <= busy_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.line_drive_low  = drive_reg;
    assign out_ch.busy_res        = busy_reg;
    assign out_ch.done_res        = done_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.read_data       = shift_reg;
    assign out_ch.conversion_done = conv_reg;
    assign out_ch.sensor_present  = present_reg;

endmodule

// ===== hw/rtl/one_wire_temp_sensor_master.sv =====
// Top level of the one-wire temperature sensor master.
// Channels: in_ch takes one word per time tick (cmd_valid, req_type, line_in);
// out_ch gives one result word per accepted tick (line drive, busy, done
// pulse, status, read data, conversion level, presence flag); cfg writes the
// eight 16-bit timing registers by index, always ready.
// Commands are taken only while idle: init, start conversion, read
// temperature, poll conversion. A missing presence reply ends the command
// with status 1.
// The result word of a tick is registered and appears in the cycle after its
// word is accepted. Throughput: one word per cycle while out_ch is ready, set
// by the combinational step between the input handshake and result register.
// Stall: while the result register is full and out_ch.ready is low, in_ch.ready
// drops and no tick advances; nothing is lost or repeated.
// Reset: sequencer idle, flags and read data cleared, timing registers at
// their default values, result register empty.
module one_wire_temp_sensor_master
    import owts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    owts_in_if.sink    in_ch,
    owts_out_if.source out_ch,
    owts_cfg_if.sink   cfg
);

    timing_t timing;

    owts_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .timing (timing)
    );

    owts_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .timing (timing),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
